@@ hdl/hpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants for the heater PID controller: field widths,
// register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int TEMP_W          = 14;
    localparam int GAIN_W          = 16;
    localparam int DRIVE_W         = 8;
    localparam int BAND_W          = 10;
    localparam int INTEG_W         = 20;
    localparam int INTEG_FRAC_BITS = 12;
    localparam int TEMP_FRAC_BITS  = 4;

    localparam int DEFAULT_GAIN_FRAC_BITS = 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RESET  = '0;
    localparam logic [GAIN_W-1:0]        GAIN_RESET         = '0;
    localparam logic [DRIVE_W-1:0]       DRIVE_MIN_RESET    = 8'd0;
    localparam logic [DRIVE_W-1:0]       DRIVE_MAX_RESET    = 8'd255;
    localparam logic [BAND_W-1:0]        AT_TEMP_BAND_RESET = 10'd80;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_TEMP  = 3'd0,
        REG_PROP_GAIN    = 3'd1,
        REG_INTEG_GAIN   = 3'd2,
        REG_DERIV_GAIN   = 3'd3,
        REG_DRIVE_MIN    = 3'd4,
        REG_DRIVE_MAX    = 3'd5,
        REG_AT_TEMP_BAND = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target_temp;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic [DRIVE_W-1:0]       drive_min;
        logic [DRIVE_W-1:0]       drive_max;
        logic [BAND_W-1:0]        at_temp_band;
    } cfg_t;

endpackage

@@ hdl/hpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_cfg_regs
// APB register file holding the controller setpoint, gains, drive limits and
// at-temperature band. Writes complete in the access phase; pready is fixed.
// ----------------------------------------------------------------------------
module hpc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output hpc_pkg::cfg_t                    cfg
);

    hpc_pkg::cfg_t    cfg_reg;
    hpc_pkg::cfg_t    cfg_next;
    hpc_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = hpc_pkg::reg_idx_t'(paddr[hpc_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                hpc_pkg::REG_TARGET_TEMP:
                    cfg_next.target_temp  = $signed(pwdata[hpc_pkg::TEMP_W-1:0]);
                hpc_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain    = pwdata[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::REG_INTEG_GAIN:
                    cfg_next.integ_gain   = pwdata[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain   = pwdata[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::REG_DRIVE_MIN:
                    cfg_next.drive_min    = pwdata[hpc_pkg::DRIVE_W-1:0];
                hpc_pkg::REG_DRIVE_MAX:
                    cfg_next.drive_max    = pwdata[hpc_pkg::DRIVE_W-1:0];
                hpc_pkg::REG_AT_TEMP_BAND:
                    cfg_next.at_temp_band = pwdata[hpc_pkg::BAND_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp  <= hpc_pkg::TARGET_TEMP_RESET;
            cfg_reg.prop_gain    <= hpc_pkg::GAIN_RESET;
            cfg_reg.integ_gain   <= hpc_pkg::GAIN_RESET;
            cfg_reg.deriv_gain   <= hpc_pkg::GAIN_RESET;
            cfg_reg.drive_min    <= hpc_pkg::DRIVE_MIN_RESET;
            cfg_reg.drive_max    <= hpc_pkg::DRIVE_MAX_RESET;
            cfg_reg.at_temp_band <= hpc_pkg::AT_TEMP_BAND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            hpc_pkg::REG_TARGET_TEMP:
                prdata = hpc_pkg::APB_DATA_W'(unsigned'(cfg_reg.target_temp));
            hpc_pkg::REG_PROP_GAIN:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.prop_gain);
            hpc_pkg::REG_INTEG_GAIN:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.integ_gain);
            hpc_pkg::REG_DERIV_GAIN:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.deriv_gain);
            hpc_pkg::REG_DRIVE_MIN:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.drive_min);
            hpc_pkg::REG_DRIVE_MAX:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.drive_max);
            hpc_pkg::REG_AT_TEMP_BAND:
                prdata = hpc_pkg::APB_DATA_W'(cfg_reg.at_temp_band);
            default:
                prdata = '0;
        endcase
    end

endmodule

@@ hdl/heater_pid_controller.sv @@
`timescale 1ns / 1ps
// Pipeline: a drive result is presented once its sample has passed the input,
// product, integrator and output registers.
// Throughput: one sample per cycle; each stage advances whenever the next is
// free, so a waiting result does not block new samples until all four fill.
// Reset: asynchronous, active low; clears valids, integrator, previous
// temperature and loads the register reset values.
// ----------------------------------------------------------------------------
// heater_pid_controller
// PID heater controller with derivative on the measurement: error, three
// gain products, clamped integrator and clamped PWM drive with an
// at-temperature flag.
// ----------------------------------------------------------------------------
module heater_pid_controller
#(
    parameter int GAIN_FRAC_BITS = hpc_pkg::DEFAULT_GAIN_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hpc_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [hpc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [hpc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [hpc_pkg::TEMP_W-1:0]     measured_temp,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [hpc_pkg::DRIVE_W-1:0]           drive_level,
    output logic                                  at_temp
);

    localparam int ERR_W      = hpc_pkg::TEMP_W + 1;
    localparam int MUL_W      = hpc_pkg::GAIN_W + 1 + ERR_W;
    localparam int PD_W       = MUL_W + 1;
    localparam int STEP_SHIFT = GAIN_FRAC_BITS + hpc_pkg::TEMP_FRAC_BITS
                              - hpc_pkg::INTEG_FRAC_BITS;
    localparam int STEP_LSH   = (STEP_SHIFT < 0) ? -STEP_SHIFT : 0;
    localparam int STEP_RSH   = (STEP_SHIFT > 0) ? STEP_SHIFT : 0;
    localparam int STEP_W     = MUL_W + STEP_LSH;
    localparam int IACC_W     = ((STEP_W > hpc_pkg::INTEG_W + 1) ? STEP_W
                                : hpc_pkg::INTEG_W + 1) + 1;
    localparam int PROD_SHIFT = GAIN_FRAC_BITS + hpc_pkg::TEMP_FRAC_BITS;
    localparam int FINE_SHIFT = PROD_SHIFT + hpc_pkg::INTEG_FRAC_BITS;
    localparam int SUM_A_W    = PD_W + hpc_pkg::INTEG_FRAC_BITS;
    localparam int SUM_B_W    = hpc_pkg::INTEG_W + PROD_SHIFT + 1;
    localparam int SUM_W      = ((SUM_A_W > SUM_B_W) ? SUM_A_W : SUM_B_W) + 1;

    hpc_pkg::cfg_t cfg;

    hpc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake and stage control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_free, s2_free, s3_free, out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: error, measurement delta, at-temperature flag
    logic signed [hpc_pkg::TEMP_W-1:0] prev_temp_reg;
    logic signed [ERR_W-1:0]           err_next, dinput_next;
    logic signed [ERR_W-1:0]           err_s1_reg, dinput_s1_reg;
    logic                              at_next, at_s1_reg;

    assign err_next    = ERR_W'(cfg.target_temp) - ERR_W'(measured_temp);
    assign dinput_next = ERR_W'(measured_temp) - ERR_W'(prev_temp_reg);
    assign at_next     = (err_next < $signed(ERR_W'(cfg.at_temp_band)))
                      && (cfg.target_temp != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_temp_reg <= '0;
        else if (s1_free && in_valid)
            prev_temp_reg <= measured_temp;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            err_s1_reg    <= err_next;
            dinput_s1_reg <= dinput_next;
            at_s1_reg     <= at_next;
        end
    end

    // Stage 2: gain products
    logic signed [MUL_W-1:0] kp_prod_next, ki_prod_next, kd_prod_next;
    logic signed [MUL_W-1:0] kp_prod_reg, ki_prod_reg, kd_prod_reg;
    logic                    at_s2_reg;

    assign kp_prod_next = MUL_W'($signed({1'b0, cfg.prop_gain}))  * MUL_W'(err_s1_reg);
    assign ki_prod_next = MUL_W'($signed({1'b0, cfg.integ_gain})) * MUL_W'(err_s1_reg);
    assign kd_prod_next = MUL_W'($signed({1'b0, cfg.deriv_gain})) * MUL_W'(dinput_s1_reg);

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            kp_prod_reg <= kp_prod_next;
            ki_prod_reg <= ki_prod_next;
            kd_prod_reg <= kd_prod_next;
            at_s2_reg   <= at_s1_reg;
        end
    end

    // Stage 3: integrator update with clamp, proportional minus derivative
    logic [hpc_pkg::INTEG_W-1:0] integrator_reg, integ_next;
    logic [hpc_pkg::INTEG_W-1:0] integ_s3_reg;
    logic signed [STEP_W-1:0]    integ_step;
    logic signed [IACC_W-1:0]    integ_sum, integ_lo, integ_hi, integ_clamped;
    logic signed [PD_W-1:0]      pd_next, pd_s3_reg;
    logic                        at_s3_reg;

    assign integ_step = (STEP_W'(ki_prod_reg) <<< STEP_LSH) >>> STEP_RSH;
    assign integ_sum  = IACC_W'(integ_step)
                      + $signed(IACC_W'(integrator_reg));
    assign integ_lo   = $signed(IACC_W'({cfg.drive_min,
                                          {hpc_pkg::INTEG_FRAC_BITS{1'b0}}}));
    assign integ_hi   = $signed(IACC_W'({cfg.drive_max,
                                          {hpc_pkg::INTEG_FRAC_BITS{1'b0}}}));

    always_comb
    begin
        if (integ_sum > integ_hi)
            integ_clamped = integ_hi;
        else if (integ_sum < integ_lo)
            integ_clamped = integ_lo;
        else
            integ_clamped = integ_sum;
    end

    assign integ_next = integ_clamped[hpc_pkg::INTEG_W-1:0];
    assign pd_next    = PD_W'(kp_prod_reg) - PD_W'(kd_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integrator_reg <= '0;
        else if (s3_free && s2_valid_reg)
            integrator_reg <= integ_next;
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            integ_s3_reg <= integ_next;
            pd_s3_reg    <= pd_next;
            at_s3_reg    <= at_s2_reg;
        end
    end

    // Stage 4: drive sum, clamp and truncate to whole counts
    logic signed [SUM_W-1:0]     drive_sum, drive_lo, drive_hi, drive_clamped;
    logic [hpc_pkg::DRIVE_W-1:0] drive_level_next, drive_level_reg;
    logic                        at_temp_reg;

    assign drive_sum = (SUM_W'(pd_s3_reg) <<< hpc_pkg::INTEG_FRAC_BITS)
                     + $signed(SUM_W'({integ_s3_reg, {PROD_SHIFT{1'b0}}}));
    assign drive_lo  = $signed(SUM_W'({cfg.drive_min, {FINE_SHIFT{1'b0}}}));
    assign drive_hi  = $signed(SUM_W'({cfg.drive_max, {FINE_SHIFT{1'b0}}}));

    always_comb
    begin
        if (drive_sum > drive_hi)
            drive_clamped = drive_hi;
        else if (drive_sum < drive_lo)
            drive_clamped = drive_lo;
        else
            drive_clamped = drive_sum;
    end

    assign drive_level_next = drive_clamped[FINE_SHIFT +: hpc_pkg::DRIVE_W];

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            drive_level_reg <= drive_level_next;
            at_temp_reg     <= at_s3_reg;
        end
    end

    assign drive_level = drive_level_reg;
    assign at_temp     = at_temp_reg;

endmodule

@@ bench/tb_heater_pid_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heater_pid_controller
// Self-checking bench for the heater PID controller. A queue of temperature
// samples feeds a clocked driver. A bit-exact model of the integrator, the
// derivative on measurement and both clamps predicts every drive transaction.
// A monitor compares drive_level and at_temp with the oldest prediction.
// Control settings change over APB only while the loop is drained. The random
// phases cycle through four idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_heater_pid_controller;

    localparam int GAIN_FRAC    = hpc_pkg::DEFAULT_GAIN_FRAC_BITS;
    localparam int PROD_SHIFT   = GAIN_FRAC + hpc_pkg::TEMP_FRAC_BITS;
    localparam int FINE_SHIFT   = PROD_SHIFT + hpc_pkg::INTEG_FRAC_BITS;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 400;
    localparam int RAND_PHASES  = 12;
    localparam int RAND_SAMPLES = 137;

    localparam logic [hpc_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic [hpc_pkg::DRIVE_W-1:0] drive;
        logic                        at;
    } drive_result_t;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [hpc_pkg::APB_ADDR_W-1:0]    paddr         = '0;
    logic [hpc_pkg::APB_DATA_W-1:0]    pwdata        = '0;
    logic [hpc_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic signed [hpc_pkg::TEMP_W-1:0] measured_temp = '0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic [hpc_pkg::DRIVE_W-1:0]       drive_level;
    logic                              at_temp;

    hpc_pkg::cfg_t ctl = '{target_temp:  hpc_pkg::TARGET_TEMP_RESET,
                           prop_gain:    hpc_pkg::GAIN_RESET,
                           integ_gain:   hpc_pkg::GAIN_RESET,
                           deriv_gain:   hpc_pkg::GAIN_RESET,
                           drive_min:    hpc_pkg::DRIVE_MIN_RESET,
                           drive_max:    hpc_pkg::DRIVE_MAX_RESET,
                           at_temp_band: hpc_pkg::AT_TEMP_BAND_RESET};

    logic [hpc_pkg::INTEG_W-1:0]       integ_acc = '0;
    logic signed [hpc_pkg::TEMP_W-1:0] last_temp = '0;

    logic signed [hpc_pkg::TEMP_W-1:0] temp_q[$];
    drive_result_t                     drive_expect_q[$];
    drive_result_t                     want;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int samples_taken = 0;
    int results_seen  = 0;
    int at_flags      = 0;
    int reg_writes    = 0;
    int settings_used = 0;
    int error_count   = 0;

    heater_pid_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .measured_temp (measured_temp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_level   (drive_level),
        .at_temp       (at_temp)
    );

    always #6 clk = ~clk;

    function automatic void predict_drive(input logic signed [hpc_pkg::TEMP_W-1:0] temp);
        longint        err;
        longint        slope;
        longint        acc;
        longint        sum;
        longint        lo_lim;
        longint        hi_lim;
        drive_result_t res;
        err   = longint'($signed(ctl.target_temp)) - longint'(temp);
        slope = longint'(temp) - longint'(last_temp);

        acc = longint'(integ_acc)
            + (((longint'(ctl.integ_gain) * err) <<< hpc_pkg::INTEG_FRAC_BITS)
               >>> PROD_SHIFT);
        hi_lim = longint'(ctl.drive_max) <<< hpc_pkg::INTEG_FRAC_BITS;
        lo_lim = longint'(ctl.drive_min) <<< hpc_pkg::INTEG_FRAC_BITS;
        if (acc > hi_lim)
            acc = hi_lim;
        else if (acc < lo_lim)
            acc = lo_lim;
        integ_acc = acc[hpc_pkg::INTEG_W-1:0];

        sum = ((longint'(ctl.prop_gain) * err) <<< hpc_pkg::INTEG_FRAC_BITS)
            + (acc <<< PROD_SHIFT)
            - ((longint'(ctl.deriv_gain) * slope) <<< hpc_pkg::INTEG_FRAC_BITS);
        hi_lim = longint'(ctl.drive_max) <<< FINE_SHIFT;
        lo_lim = longint'(ctl.drive_min) <<< FINE_SHIFT;
        if (sum > hi_lim)
            sum = hi_lim;
        else if (sum < lo_lim)
            sum = lo_lim;

        res.drive = hpc_pkg::DRIVE_W'(sum >>> FINE_SHIFT);
        res.at    = (err < longint'(ctl.at_temp_band)) && (ctl.target_temp != '0);
        if (res.at)
            at_flags++;
        last_temp = temp;
        drive_expect_q.push_back(res);
    endfunction

    function automatic logic [hpc_pkg::APB_DATA_W-1:0] pick_gain(input int shift_max);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 65535) >> $urandom_range(0, shift_max);
    endfunction

    task automatic write_reg(input logic [hpc_pkg::REG_IDX_W-1:0] idx,
                             input logic [hpc_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hpc_pkg::REG_TARGET_TEMP:
                ctl.target_temp  = value[hpc_pkg::TEMP_W-1:0];
            hpc_pkg::REG_PROP_GAIN:
                ctl.prop_gain    = value[hpc_pkg::GAIN_W-1:0];
            hpc_pkg::REG_INTEG_GAIN:
                ctl.integ_gain   = value[hpc_pkg::GAIN_W-1:0];
            hpc_pkg::REG_DERIV_GAIN:
                ctl.deriv_gain   = value[hpc_pkg::GAIN_W-1:0];
            hpc_pkg::REG_DRIVE_MIN:
                ctl.drive_min    = value[hpc_pkg::DRIVE_W-1:0];
            hpc_pkg::REG_DRIVE_MAX:
                ctl.drive_max    = value[hpc_pkg::DRIVE_W-1:0];
            hpc_pkg::REG_AT_TEMP_BAND:
                ctl.at_temp_band = value[hpc_pkg::BAND_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_settings(input int tgt,
                                  input logic [hpc_pkg::APB_DATA_W-1:0] kp,
                                  input logic [hpc_pkg::APB_DATA_W-1:0] ki,
                                  input logic [hpc_pkg::APB_DATA_W-1:0] kd,
                                  input int lo, input int hi, input int band);
        write_reg(hpc_pkg::REG_TARGET_TEMP, hpc_pkg::APB_DATA_W'(tgt));
        write_reg(hpc_pkg::REG_PROP_GAIN, kp);
        write_reg(hpc_pkg::REG_INTEG_GAIN, ki);
        write_reg(hpc_pkg::REG_DERIV_GAIN, kd);
        write_reg(hpc_pkg::REG_DRIVE_MIN, hpc_pkg::APB_DATA_W'(lo));
        write_reg(hpc_pkg::REG_DRIVE_MAX, hpc_pkg::APB_DATA_W'(hi));
        write_reg(hpc_pkg::REG_AT_TEMP_BAND, hpc_pkg::APB_DATA_W'(band));
        settings_used++;
    endtask

    task automatic queue_temps(input int temps[$]);
        foreach (temps[i])
            temp_q.push_back(hpc_pkg::TEMP_W'(temps[i]));
    endtask

    task automatic wait_drain();
        while (temp_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: hold the sample until accepted, then offer the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_drive(measured_temp);
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (temp_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    measured_temp <= temp_q.pop_front();
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (holds_served != holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (drive_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual drive %0d at %0b",
                         $time, drive_level, at_temp);
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (drive_level !== want.drive)
                begin
                    error_count++;
                    $display("%0t: drive_level mismatch, expected %0d, actual %0d",
                             $time, want.drive, drive_level);
                end
                if (at_temp !== want.at)
                begin
                    error_count++;
                    $display("%0t: at_temp mismatch, expected %0b, actual %0b",
                             $time, want.at, at_temp);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int tgt;
        int lo;
        int hi;
        int band;
        int cur;
        int pick;
        int sample;
        logic [hpc_pkg::APB_DATA_W-1:0] kp;
        logic [hpc_pkg::APB_DATA_W-1:0] ki;
        logic [hpc_pkg::APB_DATA_W-1:0] kd;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings; first sample sees a zero previous temperature.
        queue_temps('{0, 8191, -8192, 6400, -800});
        wait_drain();

        write_settings(1600, 32'h0400, 32'h0020, 32'h0200, 10, 240, 80);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        queue_temps('{1600, 1521, 1520, 1700, 0, 6400, -800, 8191, -8192, 1600});
        wait_drain();

        // Minimum above maximum, full gains, widest band.
        write_settings(-8192, 32'hFFFF, 32'hFFFF, 32'hFFFF, 200, 40, 1023);
        queue_temps('{-8192, 8191, -8192, 0});
        wait_drain();

        write_settings(8191, 32'h0100, 32'h0100, 32'h0100, 0, 0, 0);
        queue_temps('{8191, 8190, -8192});
        wait_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase

            case (ph)
                0: begin lo = 0;   hi = 255; end
                1: begin lo = 255; hi = 0;   end
                2: begin lo = 128; hi = 128; end
                default:
                    if ($urandom_range(0, 7) == 0)
                    begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(0, 255);
                    end
                    else
                    begin
                        lo = $urandom_range(0, 60);
                        hi = $urandom_range(150, 255);
                    end
            endcase

            if (ph == 3)
                tgt = 0;
            else if ($urandom_range(0, 9) == 0)
                tgt = int'($signed(hpc_pkg::TEMP_W'($urandom)));
            else
                tgt = int'($urandom_range(0, 7200)) - 800;

            if (ph == 0)
            begin
                kp = 32'hFFFF;
                ki = 32'hFFFF;
                kd = 32'hFFFF;
                band = 0;
            end
            else
            begin
                kp = pick_gain(12);
                ki = pick_gain(14);
                kd = pick_gain(12);
                band = (ph == 1) ? 1023 : $urandom_range(0, 1023);
            end

            write_settings(tgt, kp, ki, kd, lo, hi, band);
            if (ph % 5 == 2)
                write_reg(REG_UNMAPPED, $urandom);

            cur = tgt + int'($urandom_range(0, 800)) - 400;
            for (int n = 0; n < RAND_SAMPLES; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                begin
                    cur = cur + (tgt - cur) / 8 + int'($urandom_range(0, 40)) - 20;
                    if (cur > 8191)
                        cur = 8191;
                    else if (cur < -8192)
                        cur = -8192;
                    sample = cur;
                end
                else if (pick < 92)
                    sample = int'($urandom_range(0, 7200)) - 800;
                else
                    sample = int'($signed(hpc_pkg::TEMP_W'($urandom)));
                temp_q.push_back(hpc_pkg::TEMP_W'(sample));
            end

            // Back-pressure the output until the pipeline fills and stalls the input.
            if (ph == 4)
                holds_asked++;
            wait_drain();
        end

        $display("Checked %0d drive transactions from %0d samples over %0d settings",
                 results_seen, samples_taken, settings_used);
        $display("Register writes: %0d, at-temperature flags expected: %0d",
                 reg_writes, at_flags);
        if (error_count == 0 && drive_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
